// ----- hw/rtl/kfc_pkg.sv -----
// Shared types, key codes and text constants for the keypad calculator.
package kfc_pkg;

  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;
  localparam logic [7:0] KEY_EQ   = 8'h3D;
  localparam logic [7:0] KEY_ADD  = 8'h2B;
  localparam logic [7:0] KEY_SUB  = 8'h2D;
  localparam logic [7:0] KEY_MUL  = 8'h2A;
  localparam logic [7:0] KEY_DIV  = 8'h2F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    CMD_DIGIT,
    CMD_OPER,
    CMD_EQUALS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] key;
  } cmd_t;

  function automatic logic [7:0] err_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = CH_CR;
      4'd1:    ch = CH_LF;
      4'd2:    ch = 8'h45;
      4'd3:    ch = 8'h52;
      4'd4:    ch = 8'h52;
      4'd5:    ch = 8'h4F;
      4'd6:    ch = 8'h52;
      4'd7:    ch = CH_CR;
      default: ch = CH_LF;
    endcase
    return ch;
  endfunction

endpackage

// ----- hw/rtl/kfc_if.sv -----
// Valid/ready channel interfaces for key items and character items.
interface kfc_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

interface kfc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- hw/rtl/kfc_front.sv -----
// Key classifier: drops ignored keys and queues digit, operator and equals commands.
module kfc_front (
  input  logic          clk,
  input  logic          rst,
  kfc_key_if.sink       key_in,
  output logic          push_valid,
  output kfc_pkg::cmd_t push_cmd,
  input  logic          push_ready
);

  logic               phase;
  logic               is_digit;
  logic               is_oper;
  logic               is_eq;
  logic               keep;
  kfc_pkg::cmd_kind_t kind;

  always_comb begin
    is_digit = key_in.key_code inside {[kfc_pkg::KEY_ZERO:kfc_pkg::KEY_NINE]};
    is_oper  = key_in.key_code inside {kfc_pkg::KEY_ADD, kfc_pkg::KEY_SUB,
                                       kfc_pkg::KEY_MUL, kfc_pkg::KEY_DIV};
    is_eq    = (key_in.key_code == kfc_pkg::KEY_EQ);
    keep     = is_digit || (is_oper && !phase) || (is_eq && phase);
    if (is_digit) begin
      kind = kfc_pkg::CMD_DIGIT;
    end else if (is_oper) begin
      kind = kfc_pkg::CMD_OPER;
    end else begin
      kind = kfc_pkg::CMD_EQUALS;
    end
  end

  assign key_in.ready  = push_ready;
  assign push_valid    = key_in.valid && keep;
  assign push_cmd.kind = kind;
  assign push_cmd.key  = key_in.key_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (key_in.valid && key_in.ready && keep) begin
      if (kind == kfc_pkg::CMD_OPER) begin
        phase <= 1'b1;
      end else if (kind == kfc_pkg::CMD_EQUALS) begin
        phase <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/kfc_queue.sv -----
// Short command queue between the classifier and the execution engine.
module kfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  kfc_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output kfc_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);

  localparam int PW = $clog2(kfc_pkg::QDEPTH);
  localparam int CW = $clog2(kfc_pkg::QDEPTH + 1);

  kfc_pkg::cmd_t ent [kfc_pkg::QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(kfc_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = ent[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(kfc_pkg::QDEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count lost track of pop");

endmodule

// ----- hw/rtl/kfc_back.sv -----
// Execution engine: operand entry, arithmetic, divider, decimal conversion and text output.
module kfc_back #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  kfc_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  kfc_char_if.source    char_out
);

  localparam int W  = OPERAND_WIDTH;
  localparam int ND = (W * 30103) / 100000 + 1;
  localparam int BW = 4 * ND;
  localparam int CW = $clog2(W);
  localparam int DW = $clog2(ND + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_CONV,
    S_HEAD,
    S_SKIP,
    S_DIGS,
    S_TAIL,
    S_ERR
  } state_t;

  state_t          state;
  logic            phase;
  logic [1:0]      opr;
  logic [W-1:0]    opnd_a;
  logic [W-1:0]    opnd_b;
  logic [W-1:0]    res;
  logic            neg;
  logic [W-1:0]    mag;
  logic [BW-1:0]   bcd;
  logic [CW-1:0]   cnt;
  logic [DW-1:0]   dleft;
  logic [3:0]      step;
  logic [W-1:0]    rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    dvs;
  logic            qneg;
  logic            out_valid;
  logic [7:0]      out_char;
  logic            out_last;

  logic            slot_free;
  logic            pop;
  logic            emit;
  logic [W-1:0]    acc;
  logic [W-1:0]    acc_next;
  logic [W-1:0]    a_mag;
  logic [W-1:0]    b_mag;
  logic [2*W-1:0]  prod_full;
  logic [W-1:0]    arith;
  logic [W:0]      rs;
  logic [W:0]      rdiff;
  logic            ge;
  logic [W-1:0]    rem_next;
  logic [W-1:0]    quo_next;
  logic [W-1:0]    res_mag;
  logic [BW-1:0]   adj;
  logic [3:0]      top_nib;
  logic [1:0]      key_op;

  assign slot_free = !out_valid || char_out.ready;
  assign pop_ready = (state == S_IDLE) && slot_free;
  assign pop       = pop_valid && pop_ready;
  assign emit      = (pop && (pop_cmd.kind == kfc_pkg::CMD_DIGIT ||
                              pop_cmd.kind == kfc_pkg::CMD_OPER)) ||
                     (slot_free && (state inside {S_HEAD, S_DIGS, S_TAIL, S_ERR}));

  assign char_out.valid       = out_valid;
  assign char_out.out_char    = out_char;
  assign char_out.last_of_run = out_last;

  always_comb begin
    acc       = phase ? opnd_b : opnd_a;
    acc_next  = (acc << 3) + (acc << 1) + {{(W-4){1'b0}}, pop_cmd.key[3:0]};
    a_mag     = opnd_a[W-1] ? ('0 - opnd_a) : opnd_a;
    b_mag     = opnd_b[W-1] ? ('0 - opnd_b) : opnd_b;
    prod_full = opnd_a * opnd_b;
    case (opr)
      kfc_pkg::OP_ADD: arith = opnd_a + opnd_b;
      kfc_pkg::OP_SUB: arith = opnd_a - opnd_b;
      kfc_pkg::OP_MUL: arith = prod_full[W-1:0];
      default:         arith = '0;
    endcase
    rs       = {rem, quo[W-1]};
    rdiff    = rs - {1'b0, dvs};
    ge       = (rs >= {1'b0, dvs});
    rem_next = ge ? rdiff[W-1:0] : rs[W-1:0];
    quo_next = {quo[W-2:0], ge};
    res_mag  = res[W-1] ? ('0 - res) : res;
    for (int i = 0; i < ND; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
    top_nib = bcd[BW-1 -: 4];
    case (pop_cmd.key)
      kfc_pkg::KEY_SUB: key_op = kfc_pkg::OP_SUB;
      kfc_pkg::KEY_MUL: key_op = kfc_pkg::OP_MUL;
      kfc_pkg::KEY_DIV: key_op = kfc_pkg::OP_DIV;
      default:          key_op = kfc_pkg::OP_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      opr       <= kfc_pkg::OP_ADD;
      opnd_a    <= '0;
      opnd_b    <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      dleft     <= '0;
      step      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (char_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (pop_cmd.kind)
              kfc_pkg::CMD_DIGIT: begin
                if (phase) begin
                  opnd_b <= acc_next;
                end else begin
                  opnd_a <= acc_next;
                end
                out_char  <= pop_cmd.key;
                out_last  <= 1'b1;
              end
              kfc_pkg::CMD_OPER: begin
                opr       <= key_op;
                phase     <= 1'b1;
                out_char  <= pop_cmd.key;
                out_last  <= 1'b1;
              end
              kfc_pkg::CMD_EQUALS: begin
                if (opr == kfc_pkg::OP_DIV) begin
                  if (opnd_b == '0) begin
                    step  <= '0;
                    state <= S_ERR;
                  end else begin
                    rem   <= '0;
                    quo   <= a_mag;
                    dvs   <= b_mag;
                    qneg  <= opnd_a[W-1] ^ opnd_b[W-1];
                    cnt   <= '0;
                    state <= S_DIV;
                  end
                end else begin
                  res   <= arith;
                  state <= S_PREP;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            res   <= qneg ? ('0 - quo_next) : quo_next;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          neg   <= res[W-1];
          mag   <= res_mag;
          bcd   <= '0;
          cnt   <= '0;
          dleft <= DW'(ND);
          step  <= '0;
          state <= S_CONV;
        end
        S_CONV: begin
          bcd <= {adj[BW-2:0], mag[W-1]};
          mag <= {mag[W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (slot_free) begin
            out_last  <= 1'b0;
            case (step)
              4'd0:    out_char <= kfc_pkg::CH_CR;
              4'd1:    out_char <= kfc_pkg::CH_LF;
              4'd2:    out_char <= kfc_pkg::KEY_EQ;
              default: out_char <= kfc_pkg::KEY_SUB;
            endcase
            if ((step == 4'd2 && !neg) || step == 4'd3) begin
              state <= S_SKIP;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_SKIP: begin
          if (top_nib == 4'd0 && dleft > DW'(1)) begin
            bcd   <= {bcd[BW-5:0], 4'd0};
            dleft <= dleft - 1'b1;
          end else begin
            state <= S_DIGS;
          end
        end
        S_DIGS: begin
          if (slot_free) begin
            out_last  <= 1'b0;
            out_char  <= kfc_pkg::KEY_ZERO + {4'd0, top_nib};
            bcd       <= {bcd[BW-5:0], 4'd0};
            dleft     <= dleft - 1'b1;
            if (dleft == DW'(1)) begin
              step  <= '0;
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          if (slot_free) begin
            if (step == 4'd0) begin
              out_char <= kfc_pkg::CH_CR;
              out_last <= 1'b0;
              step     <= 4'd1;
            end else begin
              out_char <= kfc_pkg::CH_LF;
              out_last <= 1'b1;
              phase    <= 1'b0;
              opr      <= kfc_pkg::OP_ADD;
              opnd_a   <= '0;
              opnd_b   <= '0;
              state    <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_char  <= kfc_pkg::err_char(step);
            out_last  <= (step == 4'd8);
            if (step == 4'd8) begin
              phase  <= 1'b0;
              opr    <= kfc_pkg::OP_ADD;
              opnd_a <= '0;
              opnd_b <= '0;
              state  <= S_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dvs != '0)
    else $error("divider running with zero divisor");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL && slot_free && step == 4'd1)
      |=> (state == S_IDLE && !phase && opnd_a == '0 && opnd_b == '0))
    else $error("state not cleared after result text");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGS || state == S_SKIP) |-> dleft != '0)
    else $error("digit emission with no digits left");

endmodule

// ----- hw/rtl/keypad_four_function_calculator_unit.sv -----
// Top level of the keypad four-function calculator.
// Digit and operator keys echo via the queue entry and the output character register.
// Keys are taken 1 per cycle, while there is room, into a 2-entry command queue; the
// engine drains it at up to 1 command per cycle when idle with its output slot free. '='
// runs a restoring divider for division, then binary to decimal conversion, and sends
// 1 character per cycle, up to 16, as the sink takes them, pausing to skip leading zeros.
// Synchronous reset clears to first-operand entry with both operands zero and add selected.
module keypad_four_function_calculator_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  kfc_key_if.sink    key_in,
  kfc_char_if.source char_out
);

  logic          push_valid;
  kfc_pkg::cmd_t push_cmd;
  logic          push_ready;
  logic          pop_valid;
  kfc_pkg::cmd_t pop_cmd;
  logic          pop_ready;

  kfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  kfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  kfc_back #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .char_out  (char_out)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the keypad four-function calculator unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 460;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1_500_000;

  class calc_scoreboard;
    typedef struct {
      logic [7:0] ch;
      logic       last;
    } char_item_t;

    char_item_t  expected_chars[$];
    bit          second_phase;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [1:0]  op;
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      second_phase = 0;
      lhs = '0;
      rhs = '0;
      op = kfc_pkg::OP_ADD;
    endfunction

    function void push(logic [7:0] ch, logic last);
      char_item_t c;
      c.ch = ch;
      c.last = last;
      expected_chars.push_back(c);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function int take_key(logic [7:0] k);
      int           start_count;
      int           a;
      int           b;
      int           r;
      longint       mag;
      byte unsigned digs[12];
      int           nd;
      string        err_word;
      start_count = expected_chars.size();
      if (k == 8'h00) return 0;
      if (k >= kfc_pkg::KEY_ZERO && k <= kfc_pkg::KEY_NINE) begin
        if (!second_phase) lhs = lhs * 32'd10 + 32'(k - kfc_pkg::KEY_ZERO);
        else rhs = rhs * 32'd10 + 32'(k - kfc_pkg::KEY_ZERO);
        push(k, 1'b1);
        return 1;
      end
      if (!second_phase) begin
        case (k)
          kfc_pkg::KEY_ADD: op = kfc_pkg::OP_ADD;
          kfc_pkg::KEY_SUB: op = kfc_pkg::OP_SUB;
          kfc_pkg::KEY_MUL: op = kfc_pkg::OP_MUL;
          kfc_pkg::KEY_DIV: op = kfc_pkg::OP_DIV;
          default: return 0;
        endcase
        second_phase = 1;
        push(k, 1'b1);
        return 1;
      end
      if (k != kfc_pkg::KEY_EQ) return 0;
      a = lhs;
      b = rhs;
      case (op)
        kfc_pkg::OP_ADD: r = a + b;
        kfc_pkg::OP_SUB: r = a - b;
        kfc_pkg::OP_MUL: r = a * b;
        default: begin
          if (b == 0) begin
            err_word = "ERROR";
            push(kfc_pkg::CH_CR, 1'b0);
            push(kfc_pkg::CH_LF, 1'b0);
            for (int i = 0; i < err_word.len(); i++) push(err_word[i], 1'b0);
            push(kfc_pkg::CH_CR, 1'b0);
            push(kfc_pkg::CH_LF, 1'b1);
            clear();
            return expected_chars.size() - start_count;
          end
          if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) r = a;
          else r = a / b;
        end
      endcase
      push(kfc_pkg::CH_CR, 1'b0);
      push(kfc_pkg::CH_LF, 1'b0);
      push(kfc_pkg::KEY_EQ, 1'b0);
      if (r < 0) begin
        push(kfc_pkg::KEY_SUB, 1'b0);
        mag = -longint'(r);
      end else begin
        mag = longint'(r);
      end
      nd = 0;
      do begin
        digs[nd] = byte'(mag % 10);
        mag = mag / 10;
        nd++;
      end while (mag != 0);
      for (int i = nd - 1; i >= 0; i--) push(kfc_pkg::KEY_ZERO + digs[i], 1'b0);
      push(kfc_pkg::CH_CR, 1'b0);
      push(kfc_pkg::CH_LF, 1'b1);
      clear();
      return expected_chars.size() - start_count;
    endfunction

    function void match_char(logic [7:0] ch, logic last);
      char_item_t want;
      if (expected_chars.size() == 0) begin
        if (errors < 10) $display("unexpected char %02h last %0b", ch, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch || want.last !== last) begin
        if (errors < 10) begin
          $display("mismatch: expected char %02h last %0b, got char %02h last %0b",
                   want.ch, want.last, ch, last);
        end
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  kfc_key_if  key_in();
  kfc_char_if char_out();

  keypad_four_function_calculator_unit uut (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_in),
    .char_out (char_out)
  );

  calc_scoreboard sb = new();

  int       cycles = 0;
  int       sent_keys = 0;
  bit       hold_request = 0;
  bit       paused = 0;
  logic [7:0] op_keys [4] = '{kfc_pkg::KEY_ADD, kfc_pkg::KEY_SUB,
                              kfc_pkg::KEY_MUL, kfc_pkg::KEY_DIV};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && char_out.valid && char_out.ready) begin
      sb.match_char(char_out.out_char, char_out.last_of_run);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int digit_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 92) return $urandom_range(5, 8);
    return $urandom_range(9, 12);
  endfunction

  initial begin
    int stall_left;
    int mode_left;
    bit smooth;
    stall_left = 0;
    mode_left = 0;
    smooth = 0;
    char_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        stall_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        smooth = ($urandom_range(0, 3) == 0);
        mode_left = 200;
      end
      mode_left--;
      if (stall_left > 0) begin
        char_out.ready = 1'b0;
        stall_left--;
      end else begin
        char_out.ready = 1'b1;
        if (!smooth && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  task automatic send_key(input logic [7:0] k);
    key_in.valid = 1'b1;
    key_in.key_code = k;
    @(posedge clk);
    while (!key_in.ready) @(posedge clk);
    void'(sb.take_key(k));
    sent_keys++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      key_in.valid = 1'b0;
      key_in.key_code = 8'($urandom_range(0, 255));
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_paced(input logic [7:0] k, input bit quick);
    if (!quick && $urandom_range(0, 99) < 6) begin
      send_key(8'($urandom_range(0, 255)));
      idle_gap(pick_gap());
    end
    send_key(k);
    if (!quick) idle_gap(pick_gap());
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_key(s[i]);
      idle_gap(pick_gap());
    end
  endtask

  task automatic send_expression();
    int  kind;
    int  len;
    int  r;
    bit  quick;
    kind = $urandom_range(0, 99);
    quick = ($urandom_range(0, 3) == 0);
    if (kind < 75) begin
      len = digit_count();
      for (int i = 0; i < len; i++) begin
        send_paced(kfc_pkg::KEY_ZERO + 8'($urandom_range(0, 9)), quick);
      end
      send_paced(op_keys[$urandom_range(0, 3)], quick);
      len = digit_count();
      for (int i = 0; i < len; i++) begin
        send_paced(kfc_pkg::KEY_ZERO + 8'($urandom_range(0, 9)), quick);
      end
      send_paced(kfc_pkg::KEY_EQ, quick);
    end else if (kind < 90) begin
      len = $urandom_range(3, 10);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) send_paced(kfc_pkg::KEY_ZERO + 8'($urandom_range(0, 9)), quick);
        else if (r < 75) send_paced(op_keys[$urandom_range(0, 3)], quick);
        else if (r < 90) send_paced(kfc_pkg::KEY_EQ, quick);
        else send_paced(8'($urandom_range(0, 255)), quick);
      end
    end else begin
      len = $urandom_range(2, 6);
      for (int i = 0; i < len; i++) send_paced(8'($urandom_range(0, 255)), quick);
    end
    idle_gap(pick_gap());
  endtask

  initial begin
    key_in.valid = 1'b0;
    key_in.key_code = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_key(8'h00);
    send_key(8'hFF);
    idle_gap(pick_gap());
    send_string("=4*/0=");
    send_string("9/=");
    send_string("2147483648/4294967295=");

    hold_request = 1;
    while (sent_keys < ITEM_TARGET) begin
      if (!paused && sent_keys >= ITEM_TARGET / 2) begin
        paused = 1;
        idle_gap(1);
        while (sb.pending() != 0) @(negedge clk);
      end
      send_expression();
    end

    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
